FILE: hdl/sbbs_pkg.sv
// ----------------------------------------------------------------------------
// sbbs_pkg: shared types and constants of the spectral bin bit slicer
// Widths, register indexes, the queue entry and the log bucket classifier.
// ----------------------------------------------------------------------------
package sbbs_pkg;

   localparam int MAX_BINS    = 512;
   localparam int POS_W       = $clog2(MAX_BINS);
   localparam int NUM_BUCKETS = 16;
   localparam int BKT_W       = $clog2(NUM_BUCKETS);
   localparam int MAG_W       = 24;
   localparam int CNT_W       = 10;
   localparam int PWR_W       = 34;
   localparam int TC_W        = 11;
   localparam int SUM_W       = 13;
   localparam int NSUM_W      = 14;
   localparam int ACC_W       = 38;
   localparam int PROD_W      = 40;
   localparam int GAIN_W      = 16;
   localparam int QDEPTH      = 4;
   localparam int QPTR_W      = $clog2(QDEPTH);
   localparam int NUM_EDGES   = 6;

   localparam logic [MAG_W-1:0] MAG_ONE = 24'd16384;
   // Natural log bucket edges e^k, k = 1..6, rounded up to Q10.14.
   localparam logic [MAG_W-1:0] LN_EDGE [NUM_EDGES] = '{
      24'd44537, 24'd121063, 24'd329082, 24'd894537, 24'd2431602, 24'd6609778 };

   localparam logic [8:0]        RST_NUM_CHANNELS = 9'd282;
   localparam logic [9:0]        RST_FRAME_LEN    = 10'd564;
   localparam logic [10:0]       RST_BAUD_STEP    = 11'd1056;
   localparam logic [GAIN_W-1:0] RST_AVG_GAIN     = 16'd257;
   localparam logic [MAG_W-1:0]  RST_NOISE_AVG    = 24'd65536;

   typedef enum logic [1:0] {
      CSR_NUM_CHANNELS = 2'd0,
      CSR_FRAME_LEN    = 2'd1,
      CSR_BAUD_STEP    = 2'd2,
      CSR_AVG_GAIN     = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [8:0]        num_channels;
      logic [9:0]        frame_len;
      logic [10:0]       baud_step;
      logic [GAIN_W-1:0] avg_gain;
   } cfg_type;

   typedef struct packed {
      logic [MAG_W-1:0] mag;
      logic             last;
      logic             used;
      logic [POS_W-1:0] pos;
      logic [BKT_W-1:0] bucket;
   } entry_type;

   function automatic logic [BKT_W-1:0] bucket_of(input logic [MAG_W-1:0] m);
      logic [BKT_W:0] b;
      b = '0;
      if (m >= MAG_ONE) begin
         b = (BKT_W+1)'(1);
         for (int k = 0; k < NUM_EDGES; k++) begin
            if (m >= LN_EDGE[k]) b = b + (BKT_W+1)'(1);
         end
      end
      if (b > (BKT_W+1)'(NUM_BUCKETS-1)) b = (BKT_W+1)'(NUM_BUCKETS-1);
      return b[BKT_W-1:0];
   endfunction

endpackage

FILE: hdl/sbbs_front.sv
// ----------------------------------------------------------------------------
// sbbs_front: request intake
// Tracks the bin position, classifies each request and queues it for the back end.
// ----------------------------------------------------------------------------
module sbbs_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [8:0]                   num_channels,
   input  logic                         hold,
   input  logic                         push,
   output logic                         full,
   input  logic [sbbs_pkg::MAG_W-1:0]   magnitude,
   input  logic                         last_bin,
   output sbbs_pkg::entry_type          head,
   output logic                         head_valid,
   input  logic                         head_pop
);

   sbbs_pkg::entry_type             q_ff [sbbs_pkg::QDEPTH];
   logic [sbbs_pkg::QPTR_W-1:0]     wr_ff, rd_ff;
   logic [sbbs_pkg::QPTR_W:0]       cnt_ff, cnt_in;
   logic [sbbs_pkg::POS_W-1:0]      pos_ff, pos_in;
   sbbs_pkg::entry_type             entry;
   logic                            accept, take;

   assign full       = (cnt_ff == (sbbs_pkg::QPTR_W+1)'(sbbs_pkg::QDEPTH)) || hold;
   assign accept     = push && !full;
   assign head_valid = (cnt_ff != '0);
   assign take       = head_pop && head_valid;
   assign head       = q_ff[rd_ff];

   always_comb begin
      entry.mag    = magnitude;
      entry.last   = last_bin;
      entry.used   = (pos_ff < num_channels);
      entry.pos    = pos_ff;
      entry.bucket = sbbs_pkg::bucket_of(magnitude);
      pos_in = pos_ff;
      if (last_bin) begin
         pos_in = '0;
      end else if (pos_ff != sbbs_pkg::POS_W'(sbbs_pkg::MAX_BINS-1)) begin
         pos_in = pos_ff + 1'b1;
      end
      cnt_in = cnt_ff + (sbbs_pkg::QPTR_W+1)'(accept) - (sbbs_pkg::QPTR_W+1)'(take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
         pos_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (accept) begin
            wr_ff  <= wr_ff + 1'b1;
            pos_ff <= pos_in;
         end
         if (take) rd_ff <= rd_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) q_ff[wr_ff] <= entry;
   end

endmodule

FILE: hdl/sbbs_back.sv
// ----------------------------------------------------------------------------
// sbbs_back: decision and noise floor sequencer
// Decides channel bits, keeps the histogram and runs the end-of-frame floor update.
// ----------------------------------------------------------------------------
module sbbs_back (
   input  logic                         clock,
   input  logic                         reset,
   input  sbbs_pkg::cfg_type            cfg,
   input  sbbs_pkg::entry_type          head,
   input  logic                         head_valid,
   output logic                         head_pop,
   output logic                         clearing,
   output logic                         emit_valid,
   output logic [sbbs_pkg::POS_W-1:0]   emit_channel,
   output logic                         emit_bit,
   input  logic                         emit_ready
);

   typedef enum logic [10:0] {
      ST_CLEAR  = 11'b00000000001,
      ST_IDLE   = 11'b00000000010,
      ST_CALC1  = 11'b00000000100,
      ST_CALC2  = 11'b00000001000,
      ST_SSTART = 11'b00000010000,
      ST_SCAN   = 11'b00000100000,
      ST_SWAP   = 11'b00001000000,
      ST_DIV    = 11'b00010000000,
      ST_MSET   = 11'b00100000000,
      ST_MUL    = 11'b01000000000,
      ST_FIN    = 11'b10000000000
   } state_type;

   localparam int ST_W = sbbs_pkg::TC_W + sbbs_pkg::SUM_W;

   state_type                          state_ff, state_in;
   logic [sbbs_pkg::MAG_W-1:0]         bin_mem [sbbs_pkg::MAX_BINS];
   logic [ST_W-1:0]                    st_mem  [sbbs_pkg::MAX_BINS];
   logic [sbbs_pkg::MAG_W-1:0]         bin_rd_ff;
   logic [ST_W-1:0]                    st_rd_ff;
   logic [sbbs_pkg::POS_W-1:0]         clr_ff;
   sbbs_pkg::entry_type                item_ff;

   logic [sbbs_pkg::CNT_W-1:0]         cnt_ff [sbbs_pkg::NUM_BUCKETS];
   logic [sbbs_pkg::PWR_W-1:0]         pw_ff  [sbbs_pkg::NUM_BUCKETS];
   logic [sbbs_pkg::MAG_W-1:0]         avg_ff;
   logic                               prev_ff, ready_ff;

   logic                               level_ff;
   logic signed [1:0]                  edge_ff;
   logic signed [15:0]                 tc1_ff, sum1_ff;

   logic [sbbs_pkg::BKT_W-1:0]         i_ff, j_ff, k_ff;
   logic [sbbs_pkg::CNT_W-1:0]         best_ff;
   logic [sbbs_pkg::ACC_W-1:0]         acc_ff, quo_ff;
   logic [sbbs_pkg::NSUM_W-1:0]        n_ff, rem_ff;
   logic [5:0]                         dcnt_ff;
   logic [3:0]                         mcnt_ff;
   logic                               neg_ff, apply_ff;
   logic [sbbs_pkg::PROD_W-1:0]        mcand_ff, prod_ff;
   logic [sbbs_pkg::GAIN_W-1:0]        gain_ff;

   // Decision arithmetic.
   logic [26:0]                        thr;
   logic                               level;
   logic signed [1:0]                  edge_c;
   logic signed [15:0]                 f_s, b_s, tc0_s, sum0_s, n_s, tc1_s, sum1_s;
   logic signed [15:0]                 abs_s, tc2_s, sum2_s, tc3_s, sum3_s;
   logic [sbbs_pkg::TC_W-1:0]          tc_sat;
   logic [sbbs_pkg::SUM_W-1:0]         sum_sat;
   logic                               emit, commit, dec_now;
   logic [sbbs_pkg::NSUM_W-1:0]        n_new;
   logic [sbbs_pkg::ACC_W-1:0]         acc_new;
   logic [sbbs_pkg::NSUM_W:0]          r2;
   logic [sbbs_pkg::ACC_W-1:0]         absd;

   function automatic logic signed [15:0] scale(input logic signed [1:0] e,
                                                input logic signed [15:0] v);
      logic signed [15:0] r;
      r = '0;
      if (e == 2'sd1) r = v;
      else if (e == -2'sd1) r = -v;
      return r;
   endfunction

   assign clearing = (state_ff == ST_CLEAR);
   assign head_pop = (state_ff == ST_IDLE) && head_valid;
   assign dec_now  = ready_ff;

   always_comb begin
      thr    = {1'b0, avg_ff, 2'b00} + {2'b00, avg_ff, 1'b0};
      level  = ({3'b000, bin_rd_ff} >= thr);
      edge_c = 2'sd0;
      if (item_ff.pos != '0) begin
         if (level && !prev_ff) edge_c = 2'sd1;
         else if (!level && prev_ff) edge_c = -2'sd1;
      end
      f_s    = signed'({6'd0, cfg.frame_len});
      b_s    = signed'({5'd0, cfg.baud_step});
      tc0_s  = signed'({5'd0, st_rd_ff[ST_W-1:sbbs_pkg::SUM_W]});
      sum0_s = signed'({{3{st_rd_ff[sbbs_pkg::SUM_W-1]}}, st_rd_ff[sbbs_pkg::SUM_W-1:0]});
      n_s    = (tc0_s + f_s > b_s) ? (b_s - tc0_s) : f_s;
      tc1_s  = tc0_s + f_s;
      sum1_s = sum0_s + scale(edge_c, n_s);

      abs_s  = (sum1_ff < 0) ? -sum1_ff : sum1_ff;
      if (abs_s < f_s) begin
         tc2_s  = f_s;
         sum2_s = scale(edge_ff, f_s);
      end else begin
         tc2_s  = tc1_ff;
         sum2_s = sum1_ff;
      end
      emit = dec_now && (tc2_s >= b_s) && (sum2_s != 0);
      if (tc2_s >= b_s) begin
         tc3_s  = tc2_s - b_s;
         sum3_s = scale(edge_ff, tc3_s);
      end else begin
         tc3_s  = tc2_s;
         sum3_s = sum2_s;
      end
      if (tc3_s < 0) tc_sat = '0;
      else if (tc3_s > 16'sd2047) tc_sat = '1;
      else tc_sat = tc3_s[sbbs_pkg::TC_W-1:0];
      if (sum3_s < -16'sd4096) sum_sat = 13'h1000;
      else if (sum3_s > 16'sd4095) sum_sat = 13'h0FFF;
      else sum_sat = sum3_s[sbbs_pkg::SUM_W-1:0];
      commit = (state_ff == ST_CALC2) && (!emit || emit_ready);

      n_new   = n_ff + sbbs_pkg::NSUM_W'(best_ff);
      acc_new = acc_ff + sbbs_pkg::ACC_W'(pw_ff[k_ff]);
      r2      = {rem_ff, quo_ff[sbbs_pkg::ACC_W-1]};
      absd    = (quo_ff >= sbbs_pkg::ACC_W'(avg_ff)) ? (quo_ff - sbbs_pkg::ACC_W'(avg_ff))
                                                     : sbbs_pkg::ACC_W'(avg_ff - quo_ff[23:0]);
   end

   assign emit_valid   = (state_ff == ST_CALC2) && emit;
   assign emit_channel = item_ff.pos;
   assign emit_bit     = (sum2_s > 0);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:  if (&clr_ff) state_in = ST_IDLE;
         ST_IDLE: begin
            if (head_valid) begin
               if (head.used) state_in = ST_CALC1;
               else if (head.last) state_in = ST_SSTART;
            end
         end
         ST_CALC1:  state_in = ST_CALC2;
         ST_CALC2: begin
            if (commit) state_in = item_ff.last ? ST_SSTART : ST_IDLE;
         end
         ST_SSTART: state_in = ST_SCAN;
         ST_SCAN: begin
            if (j_ff == sbbs_pkg::BKT_W'(sbbs_pkg::NUM_BUCKETS-1)) state_in = ST_SWAP;
         end
         ST_SWAP: begin
            if ((n_new >= sbbs_pkg::NSUM_W'(cfg.num_channels[8:1])) ||
                (i_ff == sbbs_pkg::BKT_W'(sbbs_pkg::NUM_BUCKETS-2))) begin
               state_in = (n_new == '0) ? ST_FIN : ST_DIV;
            end else begin
               state_in = ST_SSTART;
            end
         end
         ST_DIV:    if (dcnt_ff == '0) state_in = ST_MSET;
         ST_MSET:   state_in = ST_MUL;
         ST_MUL:    if (mcnt_ff == '0) state_in = ST_FIN;
         ST_FIN:    state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         avg_ff   <= sbbs_pkg::RST_NOISE_AVG;
         prev_ff  <= 1'b0;
         ready_ff <= 1'b0;
         apply_ff <= 1'b0;
         for (int b = 0; b < sbbs_pkg::NUM_BUCKETS; b++) begin
            cnt_ff[b] <= '0;
            pw_ff[b]  <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) clr_ff <= clr_ff + 1'b1;
         if (commit) begin
            if (dec_now) prev_ff <= level_ff;
            cnt_ff[item_ff.bucket] <= cnt_ff[item_ff.bucket] + 1'b1;
            pw_ff[item_ff.bucket]  <= pw_ff[item_ff.bucket] +
                                      sbbs_pkg::PWR_W'(item_ff.mag);
         end
         if (state_ff == ST_SWAP) begin
            cnt_ff[k_ff] <= cnt_ff[i_ff];
            pw_ff[k_ff]  <= pw_ff[i_ff];
            cnt_ff[i_ff] <= best_ff;
            pw_ff[i_ff]  <= pw_ff[k_ff];
            apply_ff     <= (n_new != '0);
         end
         if (state_ff == ST_FIN) begin
            if (apply_ff) begin
               avg_ff <= neg_ff ? (avg_ff - prod_ff[39:16]) : (avg_ff + prod_ff[39:16]);
            end
            for (int b = 0; b < sbbs_pkg::NUM_BUCKETS; b++) begin
               cnt_ff[b] <= '0;
               pw_ff[b]  <= '0;
            end
            prev_ff  <= 1'b0;
            ready_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      bin_rd_ff <= bin_mem[head.pos];
      st_rd_ff  <= st_mem[head.pos];
      if (clearing) st_mem[clr_ff] <= '0;
      else if (commit && dec_now) st_mem[item_ff.pos] <= {tc_sat, sum_sat};
      if (commit) bin_mem[item_ff.pos] <= item_ff.mag;
   end

   always_ff @(posedge clock) begin
      if (head_pop) item_ff <= head;
      if (state_ff == ST_CALC1) begin
         level_ff <= level;
         edge_ff  <= edge_c;
         tc1_ff   <= tc1_s;
         sum1_ff  <= sum1_s;
      end
      if ((state_ff == ST_CALC2) && item_ff.last) begin
         i_ff   <= '0;
         acc_ff <= '0;
         n_ff   <= '0;
      end
      if ((state_ff == ST_IDLE) && head_valid && !head.used) begin
         i_ff   <= '0;
         acc_ff <= '0;
         n_ff   <= '0;
      end
      case (state_ff)
         ST_SSTART: begin
            k_ff    <= i_ff;
            best_ff <= cnt_ff[i_ff];
            j_ff    <= i_ff + 1'b1;
         end
         ST_SCAN: begin
            if (cnt_ff[j_ff] > best_ff) begin
               k_ff    <= j_ff;
               best_ff <= cnt_ff[j_ff];
            end
            j_ff <= j_ff + 1'b1;
         end
         ST_SWAP: begin
            acc_ff  <= acc_new;
            n_ff    <= n_new;
            i_ff    <= i_ff + 1'b1;
            quo_ff  <= acc_new;
            rem_ff  <= '0;
            dcnt_ff <= 6'(sbbs_pkg::ACC_W-1);
         end
         ST_DIV: begin
            // Restoring division, one quotient bit per cycle.
            if (r2 >= {1'b0, n_ff}) begin
               rem_ff <= sbbs_pkg::NSUM_W'(r2 - {1'b0, n_ff});
               quo_ff <= {quo_ff[sbbs_pkg::ACC_W-2:0], 1'b1};
            end else begin
               rem_ff <= r2[sbbs_pkg::NSUM_W-1:0];
               quo_ff <= {quo_ff[sbbs_pkg::ACC_W-2:0], 1'b0};
            end
            dcnt_ff <= dcnt_ff - 1'b1;
         end
         ST_MSET: begin
            neg_ff   <= (quo_ff < sbbs_pkg::ACC_W'(avg_ff));
            mcand_ff <= sbbs_pkg::PROD_W'(absd);
            gain_ff  <= cfg.avg_gain;
            prod_ff  <= '0;
            mcnt_ff  <= 4'(sbbs_pkg::GAIN_W-1);
         end
         ST_MUL: begin
            // Shift-and-add gain multiply; only the low product bits are kept.
            if (gain_ff[0]) prod_ff <= prod_ff + mcand_ff;
            mcand_ff <= {mcand_ff[sbbs_pkg::PROD_W-2:0], 1'b0};
            gain_ff  <= {1'b0, gain_ff[sbbs_pkg::GAIN_W-1:1]};
            mcnt_ff  <= mcnt_ff - 1'b1;
         end
         default: begin
         end
      endcase
   end

endmodule

FILE: hdl/spectral_bin_bit_slicer_top.sv
// ----------------------------------------------------------------------------
// spectral_bin_bit_slicer_top: spectral bin bit slicer
// Thresholds FFT bins against a rolling noise floor and slices channel bits.
// ----------------------------------------------------------------------------
//   channel  direction  handshake            payload
//   req      in         req_push / req_full  req_magnitude, req_last_bin
//   rsp      out        rsp_pop / rsp_empty  rsp_channel, rsp_bit_value
//   csr      in         csr_valid/csr_ready  csr_index, csr_wdata
//
// A used bin passes the back-end sequencer through CALC1 and CALC2, an unused bin only IDLE.
// A frame's last bin adds the floor search: a bucket scan, then, if any bins were
// counted, a restoring division and a shift-and-add gain multiply.
// After reset a pass clears all 512 channel state memory entries; req_full is high.
// A full result queue holds the sequencer; a four-entry request queue absorbs bursts.
// ----------------------------------------------------------------------------
module spectral_bin_bit_slicer_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [23:0] req_magnitude,
   input  logic        req_last_bin,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [8:0]  rsp_channel,
   output logic        rsp_bit_value,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   sbbs_pkg::cfg_type    cfg_ff;
   sbbs_pkg::entry_type  head;
   logic                 head_valid, head_pop, clearing;
   logic                 emit_valid, emit_bit, emit_ready, back_push, take;
   logic [8:0]           emit_channel;
   logic [8:0]           oq_ch_ff [2];
   logic                 oq_bit_ff [2];
   logic                 oq_wr_ff, oq_rd_ff;
   logic [1:0]           oq_cnt_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.num_channels <= sbbs_pkg::RST_NUM_CHANNELS;
         cfg_ff.frame_len    <= sbbs_pkg::RST_FRAME_LEN;
         cfg_ff.baud_step    <= sbbs_pkg::RST_BAUD_STEP;
         cfg_ff.avg_gain     <= sbbs_pkg::RST_AVG_GAIN;
      end else if (csr_valid && csr_ready) begin
         case (sbbs_pkg::csr_index_type'(csr_index))
            sbbs_pkg::CSR_NUM_CHANNELS: cfg_ff.num_channels <= csr_wdata[8:0];
            sbbs_pkg::CSR_FRAME_LEN:    cfg_ff.frame_len    <= csr_wdata[9:0];
            sbbs_pkg::CSR_BAUD_STEP:    cfg_ff.baud_step    <= csr_wdata[10:0];
            sbbs_pkg::CSR_AVG_GAIN:     cfg_ff.avg_gain     <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   sbbs_front u_front (
      .clock        (clock),
      .reset        (reset),
      .num_channels (cfg_ff.num_channels),
      .hold         (clearing),
      .push         (req_push),
      .full         (req_full),
      .magnitude    (req_magnitude),
      .last_bin     (req_last_bin),
      .head         (head),
      .head_valid   (head_valid),
      .head_pop     (head_pop)
   );

   sbbs_back u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .head         (head),
      .head_valid   (head_valid),
      .head_pop     (head_pop),
      .clearing     (clearing),
      .emit_valid   (emit_valid),
      .emit_channel (emit_channel),
      .emit_bit     (emit_bit),
      .emit_ready   (emit_ready)
   );

   assign emit_ready    = (oq_cnt_ff != 2'd2);
   assign back_push     = emit_valid && emit_ready;
   assign rsp_empty     = (oq_cnt_ff == 2'd0);
   assign take          = rsp_pop && !rsp_empty;
   assign rsp_channel   = oq_ch_ff[oq_rd_ff];
   assign rsp_bit_value = oq_bit_ff[oq_rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         oq_wr_ff  <= 1'b0;
         oq_rd_ff  <= 1'b0;
         oq_cnt_ff <= 2'd0;
      end else begin
         oq_cnt_ff <= oq_cnt_ff + 2'(back_push) - 2'(take);
         if (back_push) oq_wr_ff <= !oq_wr_ff;
         if (take) oq_rd_ff <= !oq_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (back_push) begin
         oq_ch_ff[oq_wr_ff]  <= emit_channel;
         oq_bit_ff[oq_wr_ff] <= emit_bit;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (oq_cnt_ff == 2'd2) |-> !back_push)
      else $error("result queue written while full");

   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      clearing |-> (req_full && !head_pop))
      else $error("request taken during state clearing pass");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      (take && (oq_cnt_ff == 2'd1) && !back_push) |=> rsp_empty)
      else $error("result queue not empty after last result popped");

endmodule

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench of the spectral bin bit slicer
// Streams frames of bin magnitudes through the block and checks every decided
// channel bit against a predictor kept in step with each accepted request.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SETTLE_CYCLES = 600;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int TOP_POS       = 511;

   typedef struct {
      logic [8:0] channel;
      logic       bit_value;
   } bit_decision_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [23:0] req_magnitude = '0;
   logic        req_last_bin = 1'b0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [8:0]  rsp_channel;
   logic        rsp_bit_value;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   // Predictor state and configuration.
   int          cfg_channels = 282;
   int          cfg_frame = 564;
   int          cfg_baud = 1056;
   longint      cfg_gain = 257;
   int unsigned bin_mem [512];
   int          bkt_cnt [16];
   longint      bkt_pwr [16];
   longint      noise_avg = 65536;
   int          chan_time [512];
   int          chan_sum [512];
   int          bin_pos = 0;
   bit          prev_lvl = 1'b0;
   bit          frame_done = 1'b0;

   bit_decision_type pending_bits[$];
   int            mismatches = 0;
   int            used_items = 0;
   int            send_idle_pct = 0;
   int            recv_stall_pct = 0;
   int            cycle_count = 0;
   bit            tone_on [512];

   int unsigned   ln_thresh [6] = '{44537, 121063, 329082, 894537, 2431602, 6609778};

   spectral_bin_bit_slicer_top dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_pop <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      bit_decision_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_bits.size() == 0) begin
            $error("unexpected bit decision: channel %0d bit_value %0d",
                   rsp_channel, rsp_bit_value);
            mismatches++;
         end else begin
            want = pending_bits.pop_front();
            if (rsp_channel !== want.channel) begin
               $error("channel: expected %0d, actual %0d", want.channel, rsp_channel);
               mismatches++;
            end
            if (rsp_bit_value !== want.bit_value) begin
               $error("bit_value: expected %0d, actual %0d", want.bit_value,
                      rsp_bit_value);
               mismatches++;
            end
         end
      end
   end

   function automatic int used_count();
      return (cfg_channels < TOP_POS) ? cfg_channels : TOP_POS;
   endfunction

   function automatic int log_bucket(int unsigned m);
      int b;
      if (m < 16384) return 0;
      b = 1;
      foreach (ln_thresh[k]) if (m >= ln_thresh[k]) b++;
      return (b > 15) ? 15 : b;
   endfunction

   // The most populated buckets covering half of the used bins set the floor.
   function automatic void update_floor();
      int     cnt [16];
      longint pw [16];
      int     half, n, k, tcn;
      longint acc, tp, mean, diff, delta;
      cnt = bkt_cnt;
      pw = bkt_pwr;
      half = used_count() / 2;
      n = 0;
      acc = 0;
      for (int i = 0; i < 15; i++) begin
         k = i;
         for (int j = i + 1; j < 16; j++) if (cnt[j] > cnt[k]) k = j;
         tcn = cnt[k]; tp = pw[k];
         cnt[k] = cnt[i]; pw[k] = pw[i];
         cnt[i] = tcn; pw[i] = tp;
         acc += pw[i];
         n += cnt[i];
         if (n >= half) break;
      end
      if (n > 0) begin
         mean = acc / n;
         diff = mean - noise_avg;
         delta = (diff * cfg_gain) / 65536;
         noise_avg = (noise_avg + delta) & 64'hFFFFFF;
      end
      foreach (bkt_cnt[i]) begin
         bkt_cnt[i] = 0;
         bkt_pwr[i] = 0;
      end
   endfunction

   function automatic void decide_channel(int p);
      bit lvl;
      int slope, tc, sum, n;
      lvl = (longint'(bin_mem[p]) >= noise_avg * 6);
      slope = 0;
      if (p != 0) begin
         if (lvl && !prev_lvl) slope = 1;
         else if (!lvl && prev_lvl) slope = -1;
      end
      prev_lvl = lvl;
      tc = chan_time[p];
      sum = chan_sum[p];
      n = (tc + cfg_frame > cfg_baud) ? cfg_baud - tc : cfg_frame;
      tc += cfg_frame;
      sum += slope * n;
      // A sum too small to trust restarts the integration from this frame.
      if (((sum < 0) ? -sum : sum) < cfg_frame) begin
         tc = cfg_frame;
         sum = slope * cfg_frame;
      end
      if (tc >= cfg_baud) begin
         if (sum != 0) pending_bits.push_back('{channel: 9'(p), bit_value: sum > 0});
         tc -= cfg_baud;
         sum = slope * tc;
      end
      if (tc < 0) tc = 0;
      if (tc > 2047) tc = 2047;
      if (sum < -4096) sum = -4096;
      if (sum > 4095) sum = 4095;
      chan_time[p] = tc;
      chan_sum[p] = sum;
   endfunction

   function automatic void predict_request(logic [23:0] mag, logic last);
      int p, bk;
      p = bin_pos;
      if (p < used_count()) begin
         if (frame_done) decide_channel(p);
         bin_mem[p] = mag;
         bk = log_bucket(mag);
         bkt_cnt[bk] = (bkt_cnt[bk] + 1) & 10'h3FF;
         bkt_pwr[bk] = (bkt_pwr[bk] + mag) & 64'h3_FFFF_FFFF;
         used_items++;
      end
      if (last) begin
         update_floor();
         bin_pos = 0;
         prev_lvl = 0;
         frame_done = 1;
      end else if (p < TOP_POS) begin
         bin_pos = p + 1;
      end
   endfunction

   task automatic send_bin(logic [23:0] mag, logic last);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_magnitude <= mag;
      req_last_bin <= last;
      @(posedge clock);
      while (req_full) @(posedge clock);
      predict_request(mag, last);
   endtask

   // Drain every expected bit, then give the floor search time to finish.
   task automatic settle();
      req_push <= 1'b0;
      @(posedge clock);
      while (pending_bits.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(sbbs_pkg::csr_index_type idx, int value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= 16'(value);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         sbbs_pkg::CSR_NUM_CHANNELS: cfg_channels = value & 9'h1FF;
         sbbs_pkg::CSR_FRAME_LEN:    cfg_frame = value & 10'h3FF;
         sbbs_pkg::CSR_BAUD_STEP:    cfg_baud = value & 11'h7FF;
         sbbs_pkg::CSR_AVG_GAIN:     cfg_gain = value & 16'hFFFF;
         default: begin
         end
      endcase
      @(posedge clock);
   endtask

   task automatic send_frame(int nbins, int noise_pct);
      logic [23:0] mag;
      for (int i = 0; i < nbins; i++) begin
         if ($urandom_range(99) < noise_pct) mag = 24'($urandom);
         else if (tone_on[i % 512]) mag = 24'($urandom_range(1000000, 16777215));
         else mag = 24'($urandom_range(8000, 150000));
         send_bin(mag, i == nbins - 1);
      end
   endtask

   // Every used store entry (positions 0 to 510) is written once here, so no later
   // frame reads an entry that was never filled. Bucket edges lead the frame.
   task automatic test_magnitude_extremes();
      int unsigned edges [13] = '{0, 16383, 16384, 44536, 44537, 121062, 121063,
                                  329082, 894537, 2431602, 6609777, 6609778, 16777215};
      csr_write(sbbs_pkg::CSR_NUM_CHANNELS, TOP_POS);
      for (int i = 0; i < TOP_POS; i++)
         send_bin((i < 13) ? 24'(edges[i]) : 24'($urandom), i == TOP_POS - 1);
      for (int i = 0; i < 24; i++)
         send_bin(24'($urandom_range(0, 300000)), i == 23);
   endtask

   task automatic test_special_cases();
      settle();
      // No used bins: the floor search finds nothing and the average holds.
      csr_write(sbbs_pkg::CSR_NUM_CHANNELS, 0);
      for (int i = 0; i < 3; i++) send_bin(24'($urandom), i == 2);
      settle();
      // A frame longer than the bin range: position saturates, extra bins ignored.
      csr_write(sbbs_pkg::CSR_NUM_CHANNELS, 2);
      for (int i = 0; i < 520; i++) send_bin(24'($urandom), i == 519);
      settle();
      // A short frame after a longer one leaves the tail channels undecided.
      csr_write(sbbs_pkg::CSR_NUM_CHANNELS, 12);
      foreach (tone_on[i]) tone_on[i] = (i % 3 == 1);
      send_frame(12, 0);
      send_frame(5, 0);
      send_frame(12, 0);
      send_frame(12, 0);
   endtask

   task automatic run_phase(int idx, int send_pct, int recv_pct, int target);
      int nch, flen, baud, gain, start, nbins;
      settle();
      case (idx % 4)
         1: begin flen = 94; baud = 176; gain = 65535; end
         2: begin flen = 564; baud = 1056; gain = $urandom_range(0, 65535); end
         3: begin flen = $urandom_range(94, 564); baud = $urandom_range(176, 1056); gain = 0; end
         default: begin
            flen = $urandom_range(94, 564);
            baud = $urandom_range(176, 1056);
            gain = $urandom_range(0, 65535);
         end
      endcase
      nch = (idx == 3) ? 2 : $urandom_range(4, 12);
      csr_write(sbbs_pkg::CSR_NUM_CHANNELS, nch);
      csr_write(sbbs_pkg::CSR_FRAME_LEN, flen);
      csr_write(sbbs_pkg::CSR_BAUD_STEP, baud);
      csr_write(sbbs_pkg::CSR_AVG_GAIN, gain);
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
      foreach (tone_on[i]) tone_on[i] = ($urandom_range(3) == 0);
      start = used_items;
      while (used_items - start < target) begin
         // Tones key on and off now and then, like a slow bit stream.
         foreach (tone_on[i]) if ($urandom_range(15) == 0) tone_on[i] = !tone_on[i];
         case ($urandom_range(9))
            0: nbins = $urandom_range(1, nch);
            1: nbins = nch + $urandom_range(1, 6);
            default: nbins = nch;
         endcase
         send_frame(nbins, ($urandom_range(4) == 0) ? 30 : 0);
      end
      send_idle_pct = 0;
      recv_stall_pct = 0;
   endtask

   task automatic test_random_traffic();
      int send_pcts [4] = '{0, 49, 0, 26};
      int recv_pcts [4] = '{0, 0, 49, 26};
      for (int k = 0; k < 8; k++) run_phase(k, send_pcts[k % 4], recv_pcts[k % 4], 30);
   endtask

   initial begin
      foreach (bin_mem[i]) begin
         bin_mem[i] = 0;
         chan_time[i] = 0;
         chan_sum[i] = 0;
         tone_on[i] = 0;
      end
      foreach (bkt_cnt[i]) begin
         bkt_cnt[i] = 0;
         bkt_pwr[i] = 0;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_magnitude_extremes();
      test_special_cases();
      test_random_traffic();
      req_push <= 1'b0;
      @(posedge clock);
      while (pending_bits.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_bits.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
